// ===== sv/tsr_pkg.sv =====
// Package: widths, payload structs, codes and handshake structs for the scanline rasterizer.
`default_nettype none
package tsr_pkg;

   localparam int COORD_BITS = 11;
   localparam int FRAC_BITS  = 16;
   localparam int COLOR_BITS = 32;

   // Edge position: signed, FRAC_BITS fraction bits, headroom for one step past an edge end
   localparam int POS_W = COORD_BITS + FRAC_BITS + 2;
   // Divider dividend covers both the split product and a shifted x difference
   localparam int DIV_W = (2 * COORD_BITS > COORD_BITS + FRAC_BITS) ?
                          2 * COORD_BITS : COORD_BITS + FRAC_BITS;
   localparam int NUM_W = DIV_W + 2;
   localparam int RES_W = DIV_W + 1;
   localparam int CNT_W = $clog2(DIV_W + 1);

   typedef struct packed {
      logic                  mode;
      logic [COORD_BITS-1:0] ax;
      logic [COORD_BITS-1:0] ay;
      logic [COORD_BITS-1:0] bx;
      logic [COORD_BITS-1:0] by_coord;
      logic [COORD_BITS-1:0] cx;
      logic [COORD_BITS-1:0] cy;
      logic [COLOR_BITS-1:0] fill_color;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] span_y;
      logic [COORD_BITS-1:0] span_xa;
      logic [COORD_BITS-1:0] span_xb;
      logic [COLOR_BITS-1:0] span_color;
      logic                  last_span;
   } rsp_type;

   typedef enum logic {
      CMD_LOAD,
      CMD_STEP
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      req_type item;
   } entry_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_BOTTOM,
      PH_BOTTOM_THEN_TOP,
      PH_TOP
   } phase_type;

   typedef enum logic [1:0] {
      SH_FLAT_BOTTOM,
      SH_FLAT_TOP,
      SH_GENERAL
   } shape_type;

   typedef enum logic [2:0] {
      OP_X4,
      OP_SA,
      OP_SB,
      OP_UA,
      OP_UB
   } op_type;

   typedef enum logic [1:0] {
      ST_READY,
      ST_OPER,
      ST_LAUNCH,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [DIV_W-1:0]      dividend;
      logic [COORD_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic             rem_nz;
   } div_rsp_type;

endpackage
`default_nettype wire

// ===== sv/triangle_scanline_rasterizer_unit.sv =====
// Top level: triangle scanline rasterizer with a queued front end and a set-up/walk back end.
`default_nettype none
// A load transfer (mode 0) takes three vertices and a color; the back end then sorts
// the vertices by y and works out the split point and the Q16 inverse edge slopes on
// a shared restoring divider that yields one quotient bit per cycle. A load of nonzero
// height needs two or five divisions, and step transfers queued behind it wait; a
// zero-height triangle needs no division. Each step transfer (mode 1) then yields one
// span per cycle while the response side takes them, set by the single-entry output
// register and one add per edge. A step with no triangle in progress yields nothing.
// A two-entry queue lets the request side keep transferring while the back end is busy.
module triangle_scanline_rasterizer_unit
   import tsr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic        head_valid;
   entry_type   head;
   logic        pop;
   div_req_type div_req;
   div_rsp_type div_rsp;

   tsr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   tsr_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   tsr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

// ===== sv/tsr_front.sv =====
// Front end: accepts request transfers, tags them as load or step, and queues them.
`default_nettype none
module tsr_front
   import tsr_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output logic           req_ready,
   input  wire req_type   req_data,
   output logic           head_valid,
   output entry_type      head,
   input  wire logic      pop
);

   entry_type  queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       do_pop;
   entry_type  tagged_item;

   assign req_ready  = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = queue_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign do_pop     = pop && head_valid;

   // Classify the item by its mode bit
   always_comb begin
      tagged_item.item = req_data;
      tagged_item.cmd  = req_data.mode ? CMD_STEP : CMD_LOAD;
   end

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push   ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the queue entry
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= tagged_item;
      end
   end

endmodule
`default_nettype wire

// ===== sv/tsr_div.sv =====
// Restoring divider: unsigned dividend by unsigned divisor, one quotient bit per cycle.
`default_nettype none
module tsr_div
   import tsr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   logic [COORD_BITS-1:0] den_ff, den_in;
   logic [COORD_BITS:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]      quo_ff, quo_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic [COORD_BITS:0]   shifted;
   logic                  fits;

   // One restoring step
   always_comb begin
      shifted = {rem_ff[COORD_BITS-1:0], quo_ff[DIV_W-1]};
      fits    = (shifted >= {1'b0, den_ff});
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (req.start) begin
         den_in  = req.divisor;
         rem_in  = '0;
         quo_in  = req.dividend;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            rem_in = fits ? (shifted - {1'b0, den_ff}) : shifted;
            quo_in = {quo_ff[DIV_W-2:0], fits};
            cnt_in = cnt_ff - CNT_W'(1);
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign rsp.done     = busy_ff && (cnt_ff == '0);
   assign rsp.quotient = quo_ff;
   assign rsp.rem_nz   = (rem_ff != '0);

endmodule
`default_nettype wire

// ===== sv/tsr_back.sv =====
// Back end: triangle set-up sequencer, edge walkers and span output register.
`default_nettype none
module tsr_back
   import tsr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        head_valid,
   input  wire entry_type   head,
   output logic             pop,
   output div_req_type      div_req,
   input  wire div_rsp_type div_rsp,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data
);

   localparam logic [COORD_BITS-1:0] CMAX = '1;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   shape_type shape_ff;
   op_type    op_ff;

   logic [COORD_BITS-1:0] x1_ff, y1_ff, x2_ff, y2_ff, x3_ff, y3_ff, x4_ff;
   logic [COORD_BITS-1:0] cur_row_ff, stop_row_ff;
   logic [COORD_BITS-1:0] up_start_row_ff, up_stop_row_ff;
   logic signed [POS_W-1:0] pos_a_ff, pos_b_ff, slope_a_ff, slope_b_ff;
   logic signed [POS_W-1:0] up_slope_a_ff, up_slope_b_ff;
   logic [COLOR_BITS-1:0] color_ff;
   logic signed [NUM_W-1:0] num_ff;
   logic [COORD_BITS-1:0]   den_ff;
   logic                    floor_ff;
   logic                    out_valid_ff;
   rsp_type                 out_ff;

   // Sorted vertices of the head item
   logic [COORD_BITS-1:0] sx [3];
   logic [COORD_BITS-1:0] sy [3];
   logic [COORD_BITS-1:0] tx, ty;

   // Operand selection
   logic signed [COORD_BITS:0] sel_dx;
   logic [COORD_BITS-1:0]      sel_dy;
   logic                       op_last;
   logic signed [2*COORD_BITS+1:0] prod;
   logic signed [NUM_W-1:0]    sel_num;
   logic signed [NUM_W-1:0]    num_abs;
   logic signed [RES_W-1:0]    res;

   logic out_free, step_go, load_go, at_end;

   // Stable sort by y
   always_comb begin
      tx = '0;
      ty = '0;
      sx[0] = head.item.ax; sy[0] = head.item.ay;
      sx[1] = head.item.bx; sy[1] = head.item.by_coord;
      sx[2] = head.item.cx; sy[2] = head.item.cy;
      if (sy[0] > sy[1]) begin
         tx = sx[0]; ty = sy[0];
         sx[0] = sx[1]; sy[0] = sy[1]; sx[1] = tx; sy[1] = ty;
      end
      if (sy[1] > sy[2]) begin
         tx = sx[1]; ty = sy[1];
         sx[1] = sx[2]; sy[1] = sy[2]; sx[2] = tx; sy[2] = ty;
         if (sy[0] > sy[1]) begin
            tx = sx[0]; ty = sy[0];
            sx[0] = sx[1]; sy[0] = sy[1]; sx[1] = tx; sy[1] = ty;
         end
      end
   end

   // Pick numerator and denominator of the current set-up division
   always_comb begin
      sel_dx = '0;
      sel_dy = '0;
      unique case (op_ff)
         OP_X4: begin
            sel_dx = $signed({1'b0, x3_ff}) - $signed({1'b0, x1_ff});
            sel_dy = y3_ff - y1_ff;
         end
         OP_SA: begin
            if (shape_ff == SH_FLAT_TOP) begin
               sel_dx = $signed({1'b0, x3_ff}) - $signed({1'b0, x1_ff});
               sel_dy = y3_ff - y1_ff;
            end else begin
               sel_dx = $signed({1'b0, x2_ff}) - $signed({1'b0, x1_ff});
               sel_dy = y2_ff - y1_ff;
            end
         end
         OP_SB: begin
            unique case (shape_ff)
               SH_FLAT_BOTTOM: begin
                  sel_dx = $signed({1'b0, x3_ff}) - $signed({1'b0, x1_ff});
                  sel_dy = y3_ff - y1_ff;
               end
               SH_FLAT_TOP: begin
                  sel_dx = $signed({1'b0, x3_ff}) - $signed({1'b0, x2_ff});
                  sel_dy = y3_ff - y2_ff;
               end
               SH_GENERAL: begin
                  sel_dx = $signed({1'b0, x4_ff}) - $signed({1'b0, x1_ff});
                  sel_dy = y2_ff - y1_ff;
               end
               default: begin
                  sel_dx = '0;
                  sel_dy = '0;
               end
            endcase
         end
         OP_UA: begin
            sel_dx = $signed({1'b0, x3_ff}) - $signed({1'b0, x2_ff});
            sel_dy = y3_ff - y2_ff;
         end
         OP_UB: begin
            sel_dx = $signed({1'b0, x3_ff}) - $signed({1'b0, x4_ff});
            sel_dy = y3_ff - y2_ff;
         end
         default: begin
            sel_dx = '0;
            sel_dy = '0;
         end
      endcase
      op_last = (shape_ff == SH_GENERAL) ? (op_ff == OP_UB) : (op_ff == OP_SB);
      prod    = $signed({1'b0, y2_ff - y1_ff}) * sel_dx;
      sel_num = (op_ff == OP_X4) ? NUM_W'(prod) : (NUM_W'(sel_dx) <<< FRAC_BITS);
   end

   // Divider launch and signed result
   always_comb begin
      num_abs          = num_ff[NUM_W-1] ? -num_ff : num_ff;
      div_req.start    = (state_ff == ST_LAUNCH);
      div_req.dividend = num_abs[DIV_W-1:0];
      div_req.divisor  = den_ff;
      res = $signed({1'b0, div_rsp.quotient});
      if (num_ff[NUM_W-1]) begin
         res = -res;
         if (floor_ff && div_rsp.rem_nz) begin
            res = res - RES_W'(1);
         end
      end
   end

   function automatic logic [COORD_BITS-1:0] pos_floor(input logic signed [POS_W-1:0] p);
      logic [POS_W-FRAC_BITS-1:0] v;
      v = p[POS_W-1:FRAC_BITS];
      if (p[POS_W-1]) begin
         return '0;
      end
      if (v > (POS_W-FRAC_BITS)'(CMAX)) begin
         return CMAX;
      end
      return v[COORD_BITS-1:0];
   endfunction

   assign out_free = !out_valid_ff || rsp_ready;
   assign at_end   = (cur_row_ff == stop_row_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_READY:  state_in = load_go ? ST_OPER : ST_READY;
         ST_OPER: begin
            if (sel_dy == '0) begin
               state_in = op_last ? ST_READY : ST_OPER;
            end else begin
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: state_in = ST_WAIT;
         ST_WAIT: begin
            if (div_rsp.done) begin
               state_in = op_last ? ST_READY : ST_OPER;
            end
         end
         default:   state_in = ST_READY;
      endcase
   end

   // Control strobes
   always_comb begin
      pop           = 1'b0;
      load_go       = 1'b0;
      step_go       = 1'b0;
      unique case (state_ff)
         ST_READY: begin
            if (head_valid) begin
               if (head.cmd == CMD_LOAD) begin
                  pop     = 1'b1;
                  load_go = 1'b1;
               end else if (phase_ff == PH_IDLE) begin
                  pop = 1'b1;
               end else if (out_free) begin
                  pop     = 1'b1;
                  step_go = 1'b1;
               end
            end
         end
         ST_LAUNCH, ST_OPER, ST_WAIT: pop = 1'b0;
         default: pop = 1'b0;
      endcase
   end

   // Walk phase
   always_comb begin
      phase_in = phase_ff;
      if (load_go) begin
         if (sy[1] == sy[2]) begin
            phase_in = PH_BOTTOM;
         end else if (sy[0] == sy[1]) begin
            phase_in = PH_TOP;
         end else begin
            phase_in = PH_BOTTOM_THEN_TOP;
         end
      end else if (step_go && at_end) begin
         phase_in = (phase_ff == PH_BOTTOM_THEN_TOP) ? PH_TOP : PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_READY;
         phase_ff     <= PH_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         if (step_go) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Set-up, edge walk and output datapath
   always_ff @(posedge clock) begin
      if (load_go) begin
         x1_ff    <= sx[0]; y1_ff <= sy[0];
         x2_ff    <= sx[1]; y2_ff <= sy[1];
         x3_ff    <= sx[2]; y3_ff <= sy[2];
         color_ff <= head.item.fill_color;
         if (sy[1] == sy[2]) begin
            shape_ff    <= SH_FLAT_BOTTOM;
            op_ff       <= OP_SA;
            pos_a_ff    <= POS_W'({sx[0], {FRAC_BITS{1'b0}}});
            pos_b_ff    <= POS_W'({sx[0], {FRAC_BITS{1'b0}}});
            cur_row_ff  <= sy[0];
            stop_row_ff <= sy[1];
         end else if (sy[0] == sy[1]) begin
            shape_ff    <= SH_FLAT_TOP;
            op_ff       <= OP_SA;
            pos_a_ff    <= POS_W'({sx[2], {FRAC_BITS{1'b0}}});
            pos_b_ff    <= POS_W'({sx[2], {FRAC_BITS{1'b0}}});
            cur_row_ff  <= sy[2];
            stop_row_ff <= sy[0] + COORD_BITS'(1);
         end else begin
            shape_ff        <= SH_GENERAL;
            op_ff           <= OP_X4;
            pos_a_ff        <= POS_W'({sx[0], {FRAC_BITS{1'b0}}});
            pos_b_ff        <= POS_W'({sx[0], {FRAC_BITS{1'b0}}});
            cur_row_ff      <= sy[0];
            stop_row_ff     <= sy[1];
            up_start_row_ff <= sy[2];
            up_stop_row_ff  <= sy[1] + COORD_BITS'(1);
         end
      end

      // Latch operands, or store a zero slope for a flat edge
      if (state_ff == ST_OPER) begin
         num_ff   <= sel_num;
         den_ff   <= sel_dy;
         floor_ff <= (op_ff == OP_X4);
         if (sel_dy == '0) begin
            unique case (op_ff)
               OP_SA:   slope_a_ff    <= '0;
               OP_SB:   slope_b_ff    <= '0;
               OP_UA:   up_slope_a_ff <= '0;
               OP_UB:   up_slope_b_ff <= '0;
               OP_X4:   x4_ff         <= x1_ff;
               default: x4_ff         <= x1_ff;
            endcase
            op_ff <= op_type'(op_ff + 3'd1);
         end
      end

      // Store the division result and advance
      if (state_ff == ST_WAIT && div_rsp.done) begin
         unique case (op_ff)
            OP_X4:   x4_ff         <= x1_ff + res[COORD_BITS-1:0];
            OP_SA:   slope_a_ff    <= POS_W'(res);
            OP_SB:   slope_b_ff    <= POS_W'(res);
            OP_UA:   up_slope_a_ff <= POS_W'(res);
            OP_UB:   up_slope_b_ff <= POS_W'(res);
            default: x4_ff         <= x4_ff;
         endcase
         op_ff <= op_type'(op_ff + 3'd1);
      end

      // Emit one span and step both edges, or reload them for the top part at the split row
      if (step_go) begin
         out_ff.span_y     <= cur_row_ff;
         out_ff.span_xa    <= pos_floor(pos_a_ff);
         out_ff.span_xb    <= pos_floor(pos_b_ff);
         out_ff.span_color <= color_ff;
         out_ff.last_span  <= at_end && (phase_ff != PH_BOTTOM_THEN_TOP);
         if (phase_ff == PH_TOP) begin
            pos_a_ff <= pos_a_ff - slope_a_ff;
            pos_b_ff <= pos_b_ff - slope_b_ff;
            if (!at_end) begin
               cur_row_ff <= cur_row_ff - COORD_BITS'(1);
            end
         end else if (!at_end) begin
            pos_a_ff   <= pos_a_ff + slope_a_ff;
            pos_b_ff   <= pos_b_ff + slope_b_ff;
            cur_row_ff <= cur_row_ff + COORD_BITS'(1);
         end else if (phase_ff == PH_BOTTOM_THEN_TOP) begin
            pos_a_ff    <= POS_W'({x3_ff, {FRAC_BITS{1'b0}}});
            pos_b_ff    <= POS_W'({x3_ff, {FRAC_BITS{1'b0}}});
            slope_a_ff  <= up_slope_a_ff;
            slope_b_ff  <= up_slope_b_ff;
            cur_row_ff  <= up_start_row_ff;
            stop_row_ff <= up_stop_row_ff;
         end else begin
            pos_a_ff <= pos_a_ff + slope_a_ff;
            pos_b_ff <= pos_b_ff + slope_b_ff;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
`default_nettype wire

// ===== verif/span_checker.sv =====
// Span checker: watches both channels, predicts each span and compares it with the block's output.
`timescale 1ns / 100ps
`default_nettype none
module span_checker
   import tsr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_ready,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending
);

   localparam longint ONE_Q  = longint'(1) << FRAC_BITS;
   localparam longint XMAX   = (longint'(1) << COORD_BITS) - 1;

   // Predicted walker state
   phase_type walk_phase;
   longint    row_now, row_last, edge_a, edge_b, step_a, step_b;
   longint    top_x, top_first, top_last, top_step_a, top_step_b;
   logic [COLOR_BITS-1:0] color_held;

   rsp_type spans_due[$];

   function automatic longint edge_step(longint dx, longint dy);
      if (dy == 0) return 0;
      return (dx * ONE_Q) / dy;
   endfunction

   function automatic logic [COORD_BITS-1:0] pixel_of(longint p);
      longint v;
      if (p < 0) return '0;
      v = p >>> FRAC_BITS;
      if (v > XMAX) v = XMAX;
      return v[COORD_BITS-1:0];
   endfunction

   // Sort the vertices and set up the walk, with both parts for a general triangle
   task automatic load_triangle(input req_type it);
      longint px[3], py[3], t, num, den, q, x4;
      px[0] = it.ax; py[0] = it.ay;
      px[1] = it.bx; py[1] = it.by_coord;
      px[2] = it.cx; py[2] = it.cy;
      color_held = it.fill_color;
      if (py[0] > py[1]) begin
         t = px[0]; px[0] = px[1]; px[1] = t;
         t = py[0]; py[0] = py[1]; py[1] = t;
      end
      if (py[1] > py[2]) begin
         t = px[1]; px[1] = px[2]; px[2] = t;
         t = py[1]; py[1] = py[2]; py[2] = t;
         if (py[0] > py[1]) begin
            t = px[0]; px[0] = px[1]; px[1] = t;
            t = py[0]; py[0] = py[1]; py[1] = t;
         end
      end
      if (py[1] == py[2]) begin
         walk_phase = PH_BOTTOM;
         edge_a = px[0] * ONE_Q; edge_b = edge_a;
         step_a = edge_step(px[1] - px[0], py[1] - py[0]);
         step_b = edge_step(px[2] - px[0], py[2] - py[0]);
         row_now = py[0]; row_last = py[1];
      end else if (py[0] == py[1]) begin
         walk_phase = PH_TOP;
         edge_a = px[2] * ONE_Q; edge_b = edge_a;
         step_a = edge_step(px[2] - px[0], py[2] - py[0]);
         step_b = edge_step(px[2] - px[1], py[2] - py[1]);
         row_now = py[2]; row_last = py[0] + 1;
      end else begin
         num = (py[1] - py[0]) * (px[2] - px[0]);
         den = py[2] - py[0];
         q = num / den;
         if (num % den != 0 && num < 0) q = q - 1;
         x4 = px[0] + q;
         walk_phase = PH_BOTTOM_THEN_TOP;
         edge_a = px[0] * ONE_Q; edge_b = edge_a;
         step_a = edge_step(px[1] - px[0], py[1] - py[0]);
         step_b = edge_step(x4 - px[0], py[1] - py[0]);
         row_now = py[0]; row_last = py[1];
         top_x = px[2]; top_first = py[2]; top_last = py[1] + 1;
         top_step_a = edge_step(px[2] - px[1], py[2] - py[1]);
         top_step_b = edge_step(px[2] - x4, py[2] - py[1]);
      end
   endtask

   // Emit one span and advance the walker
   task automatic next_span();
      rsp_type s;
      logic    at_end;
      at_end       = (row_now == row_last);
      s.span_y     = row_now[COORD_BITS-1:0];
      s.span_xa    = pixel_of(edge_a);
      s.span_xb    = pixel_of(edge_b);
      s.span_color = color_held;
      s.last_span  = at_end && walk_phase != PH_BOTTOM_THEN_TOP;
      spans_due.push_back(s);
      if (walk_phase == PH_TOP) begin
         edge_a -= step_a; edge_b -= step_b;
         if (at_end) walk_phase = PH_IDLE;
         else row_now = (row_now - 1) & XMAX;
      end else begin
         edge_a += step_a; edge_b += step_b;
         if (!at_end) begin
            row_now = (row_now + 1) & XMAX;
         end else if (walk_phase == PH_BOTTOM_THEN_TOP) begin
            walk_phase = PH_TOP;
            edge_a = top_x * ONE_Q; edge_b = edge_a;
            step_a = top_step_a; step_b = top_step_b;
            row_now = top_first; row_last = top_last;
         end else begin
            walk_phase = PH_IDLE;
         end
      end
   endtask

   assign pending = spans_due.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         walk_phase = PH_IDLE;
         row_now = 0; row_last = 0; edge_a = 0; edge_b = 0; step_a = 0; step_b = 0;
         top_x = 0; top_first = 0; top_last = 0; top_step_a = 0; top_step_b = 0;
         color_held = '0;
         spans_due.delete();
         fail_count = 0;
      end else begin
         // Predict from an accepted request transfer
         if (req_valid && req_ready) begin
            if (req_data.mode == 1'b0) load_triangle(req_data);
            else if (walk_phase != PH_IDLE) next_span();
         end
         // Compare an accepted response transfer
         if (rsp_valid && rsp_ready) begin
            if (spans_due.size() == 0) begin
               $display("%0t: unexpected span %p", $time, rsp_data);
               fail_count++;
            end else begin
               want = spans_due.pop_front();
               if (want !== rsp_data) begin
                  $display("%0t: span mismatch expected %p actual %p", $time, want, rsp_data);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Testbench top: clock, reset, request and response drivers and the final verdict.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import tsr_pkg::*;

   localparam int ITEM_GOAL   = 1100;
   localparam int CYCLE_LIMIT = 1000000;

   logic    clock, reset;
   logic    req_valid, req_ready, rsp_valid, rsp_ready;
   req_type req_data;
   rsp_type rsp_data;
   int      fail_count, pending, items_sent, cycles;
   logic    no_gaps;

   triangle_scanline_rasterizer_unit i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   span_checker i_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .fail_count, .pending
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic req_type make_item(logic m, int ax, int ay, int bx, int by,
                                         int cx, int cy, logic [31:0] col);
      req_type it;
      it.mode = m;
      it.ax = COORD_BITS'(ax); it.ay = COORD_BITS'(ay);
      it.bx = COORD_BITS'(bx); it.by_coord = COORD_BITS'(by);
      it.cx = COORD_BITS'(cx); it.cy = COORD_BITS'(cy);
      it.fill_color = col;
      return it;
   endfunction

   function automatic int gap_draw();
      if (no_gaps) return 0;
      return $urandom_range(0, 14);
   endfunction

   // Drive one request and hold it until the transfer
   task automatic send(input req_type it);
      int   g;
      logic took;
      g = gap_draw();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do begin
         @(negedge clock) took = req_ready;
         @(posedge clock);
      end while (!took);
      items_sent++;
   endtask

   task automatic steps(input int n);
      repeat (n) send(make_item(1'b1, $urandom_range(0, 2047), $urandom_range(0, 2047),
                                $urandom_range(0, 2047), $urandom_range(0, 2047),
                                $urandom_range(0, 2047), $urandom_range(0, 2047),
                                $urandom()));
   endtask

   // Random response stalls
   initial begin
      int   g;
      logic took;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         g = gap_draw();
         if (g > 0) begin
            rsp_ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do begin
            @(negedge clock) took = rsp_valid;
            @(posedge clock);
         end while (!took);
      end
   end

   initial begin
      int y0, spread, ya, yb, yc, lo, hi, n;
      cycles = 0; items_sent = 0; no_gaps = 1'b0;
      req_valid = 1'b0;
      req_data  = '0;
      reset     = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: step while idle, zero height, flat cases, stable sort, extremes
      send(make_item(1'b1, 0, 0, 0, 0, 0, 0, 32'h0));
      send(make_item(1'b0, 2047, 500, 0, 500, 9, 500, 32'hFFFF_FFFF));
      steps(2);
      send(make_item(1'b0, 10, 20, 0, 24, 30, 24, 32'h1234_5678));
      steps(6);
      send(make_item(1'b0, 0, 2047, 2047, 2047, 1000, 2043, 32'hA5A5_5A5A));
      steps(5);
      send(make_item(1'b0, 0, 2040, 2047, 2047, 5, 2043, 32'h5A5A_A5A5));
      steps(9);
      // Full-range vertices, then a load that drops that triangle in progress
      send(make_item(1'b0, 0, 0, 2047, 2047, 2047, 0, 32'hDEAD_BEEF));
      steps(3);
      send(make_item(1'b0, 3, 7, 9, 3, 0, 11, 32'h0F0F_0F0F));
      steps(12);

      // Let every span drain before the random part
      wait (pending == 0);
      repeat (200) @(posedge clock);

      // Random: mostly well-formed triangles of small height, some noise
      while (items_sent < ITEM_GOAL) begin
         if ($urandom_range(0, 150) == 0) no_gaps = ~no_gaps;
         if ($urandom_range(0, 9) == 0) begin
            send(make_item($urandom_range(0, 1), $urandom_range(0, 2047),
                           $urandom_range(0, 2047), $urandom_range(0, 2047),
                           $urandom_range(0, 2047), $urandom_range(0, 2047),
                           $urandom_range(0, 2047), $urandom()));
         end else begin
            y0 = $urandom_range(0, 2047);
            spread = ($urandom_range(0, 30) == 0) ? 200 : 12;
            ya = y0 + $urandom_range(0, spread); if (ya > 2047) ya = 2047;
            yb = y0 + $urandom_range(0, spread); if (yb > 2047) yb = 2047;
            yc = y0 + $urandom_range(0, spread); if (yc > 2047) yc = 2047;
            case ($urandom_range(0, 5))
               0: yb = ya;
               1: yc = yb;
               2: begin yb = ya; yc = ya; end
               default: ;
            endcase
            send(make_item(1'b0, $urandom_range(0, 2047), ya, $urandom_range(0, 2047), yb,
                           $urandom_range(0, 2047), yc, $urandom()));
            lo = ya; hi = ya;
            if (yb < lo) lo = yb; if (yc < lo) lo = yc;
            if (yb > hi) hi = yb; if (yc > hi) hi = yc;
            n = hi - lo + 3 - $urandom_range(0, 4);
            if (n > 0) steps(n);
         end
      end
      req_valid <= 1'b0;

      wait (pending == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
sv/tsr_pkg.sv
sv/tsr_front.sv
sv/tsr_div.sv
sv/tsr_back.sv
sv/triangle_scanline_rasterizer_unit.sv
verif/span_checker.sv
verif/testbench.sv
